@@ hdl/palette_color_cycling_macros.svh @@
// ----------------------------------------------------------------------------
// palette color cycling assertion macros
// same-cycle and next-cycle implication checks on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PALETTE_COLOR_CYCLING_MACROS_SVH
`define PALETTE_COLOR_CYCLING_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PCC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette color cycling check failed");

// antecedent implies consequent in the next cycle
`define PCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette color cycling check failed");

`endif

@@ hdl/palcc_pkg.sv @@
// ----------------------------------------------------------------------------
// palcc_pkg
// shared types, codes and constants of the palette color cycling unit
// ----------------------------------------------------------------------------
package palcc_pkg;

	localparam int DEF_PALETTE_SIZE = 256;
	localparam int DEF_NUM_RANGES   = 8;
	localparam int DIV_STEPS        = 16;
	localparam int DCW              = $clog2(DIV_STEPS);

	typedef enum logic [1:0] {
		CMD_LOAD_PAL   = 2'd0,
		CMD_LOAD_RANGE = 2'd1,
		CMD_QUERY      = 2'd2,
		CMD_NONE       = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  color_index;
		logic [23:0] color_value;
		logic [2:0]  slot_number;
		logic [7:0]  first_entry;
		logic [7:0]  last_entry;
		logic [15:0] cycle_rate;
		logic        reverse_dir;
		logic [31:0] frame_time;
		logic        blend_on;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  queried_index;
		logic [23:0] shown_color;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_SUM,
		ST_DIV,
		ST_ADJ,
		ST_RD0,
		ST_RD1,
		ST_BLEND,
		ST_PLAIN,
		ST_PLAIN_CAP,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_C0,
		RD_C1
	} rd_sel_t;

	typedef struct packed {
		logic    accept_query;
		logic    wr_pal;
		logic    wr_rng;
		logic    scan_step;
		logic    mul_hi;
		logic    mul_lo;
		logic    sum;
		logic    div_step;
		logic    adj;
		rd_sel_t rd_sel;
		logic    cap_plain;
		logic    cap_rgb0;
		logic    blend;
	} ctl_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic div_last;
		logic blend_on;
	} sts_t;

endpackage

@@ hdl/palcc_ctrl.sv @@
// ----------------------------------------------------------------------------
// palcc_ctrl
// sequencer: decodes loads, and for queries range scan, scaling, modulo, palette reads, blend
// ----------------------------------------------------------------------------
module palcc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [1:0]      req_cmd,
	input  palcc_pkg::sts_t sts,
	output palcc_pkg::ctl_t ctl,
	output logic            busy,
	output logic            done
);

	palcc_pkg::state_t state_q, state_d;
	logic accept;

	assign accept = start && (state_q == palcc_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= palcc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			palcc_pkg::ST_IDLE: begin
				if (accept && (req_cmd == palcc_pkg::CMD_QUERY)) begin
					state_d = palcc_pkg::ST_SCAN;
				end
			end
			palcc_pkg::ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = sts.hit ? palcc_pkg::ST_MUL_HI : palcc_pkg::ST_PLAIN;
				end
			end
			palcc_pkg::ST_MUL_HI:    state_d = palcc_pkg::ST_MUL_LO;
			palcc_pkg::ST_MUL_LO:    state_d = palcc_pkg::ST_SUM;
			palcc_pkg::ST_SUM:       state_d = palcc_pkg::ST_DIV;
			palcc_pkg::ST_DIV: begin
				if (sts.div_last) begin
					state_d = palcc_pkg::ST_ADJ;
				end
			end
			palcc_pkg::ST_ADJ:       state_d = palcc_pkg::ST_RD0;
			palcc_pkg::ST_RD0:       state_d = palcc_pkg::ST_RD1;
			palcc_pkg::ST_RD1: begin
				state_d = sts.blend_on ? palcc_pkg::ST_BLEND : palcc_pkg::ST_DONE;
			end
			palcc_pkg::ST_BLEND:     state_d = palcc_pkg::ST_DONE;
			palcc_pkg::ST_PLAIN:     state_d = palcc_pkg::ST_PLAIN_CAP;
			palcc_pkg::ST_PLAIN_CAP: state_d = palcc_pkg::ST_DONE;
			palcc_pkg::ST_DONE:      state_d = palcc_pkg::ST_IDLE;
			default:                 state_d = palcc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		ctl.rd_sel = palcc_pkg::RD_IDX;
		busy       = (state_q != palcc_pkg::ST_IDLE);
		done       = 1'b0;
		unique case (state_q)
			palcc_pkg::ST_IDLE: begin
				ctl.wr_pal       = accept && (req_cmd == palcc_pkg::CMD_LOAD_PAL);
				ctl.wr_rng       = accept && (req_cmd == palcc_pkg::CMD_LOAD_RANGE);
				ctl.accept_query = accept && (req_cmd == palcc_pkg::CMD_QUERY);
			end
			palcc_pkg::ST_SCAN:      ctl.scan_step = !sts.scan_done;
			palcc_pkg::ST_MUL_HI:    ctl.mul_hi = 1'b1;
			palcc_pkg::ST_MUL_LO:    ctl.mul_lo = 1'b1;
			palcc_pkg::ST_SUM:       ctl.sum = 1'b1;
			palcc_pkg::ST_DIV:       ctl.div_step = 1'b1;
			palcc_pkg::ST_ADJ:       ctl.adj = 1'b1;
			palcc_pkg::ST_RD0:       ctl.rd_sel = palcc_pkg::RD_C0;
			palcc_pkg::ST_RD1: begin
				ctl.rd_sel   = palcc_pkg::RD_C1;
				ctl.cap_rgb0 = 1'b1;
			end
			palcc_pkg::ST_BLEND:     ctl.blend = 1'b1;
			palcc_pkg::ST_PLAIN:     ctl.rd_sel = palcc_pkg::RD_IDX;
			palcc_pkg::ST_PLAIN_CAP: ctl.cap_plain = 1'b1;
			palcc_pkg::ST_DONE:      done = 1'b1;
			default:                 done = 1'b0;
		endcase
	end

endmodule

@@ hdl/palcc_dp.sv @@
// ----------------------------------------------------------------------------
// palcc_dp
// palette memory, range table, frame scaling, serial modulo and color blend
// ----------------------------------------------------------------------------
module palcc_dp #(
	parameter int PALETTE_SIZE = palcc_pkg::DEF_PALETTE_SIZE,
	parameter int NUM_RANGES   = palcc_pkg::DEF_NUM_RANGES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata,
	input  palcc_pkg::in_item_t  request,
	input  palcc_pkg::ctl_t      ctl,
	output palcc_pkg::sts_t      sts,
	output palcc_pkg::out_item_t result
);

	localparam int AW    = $clog2(PALETTE_SIZE);
	localparam int RIW   = (NUM_RANGES > 1) ? $clog2(NUM_RANGES) : 1;
	localparam int CW    = $clog2(NUM_RANGES + 1);
	localparam int DCW_W = palcc_pkg::DCW;

	logic [23:0] pal_mem [PALETTE_SIZE];
	logic [23:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic [7:0]  rng_first_q [NUM_RANGES];
	logic [7:0]  rng_last_q  [NUM_RANGES];
	logic [15:0] rng_speed_q [NUM_RANGES];
	logic        rng_bwd_q   [NUM_RANGES];
	logic [3:0]  cnt_q;
	logic [CW-1:0] cnt_sat;

	logic [7:0]  idx_q;
	logic [31:0] ft_q;
	logic        blend_q;
	logic [CW-1:0] scan_q;
	logic        hit_q;
	logic [7:0]  lo_q;
	logic [8:0]  n_q;
	logic [15:0] rate_q;
	logic        bwd_q;

	logic [31:0] phi_q, plo_q, prod;
	logic [15:0] mul_a;
	logic [31:0] s_sum;
	logic [7:0]  w1_q;
	logic [15:0] dvd_q;
	logic [8:0]  rem_q;
	logic [DCW_W-1:0] div_cnt_q;
	logic [9:0]  div_t;
	logic [8:0]  rem_next;

	logic [7:0]  off_fwd, off_use, pos, c0, c0_q, c1;
	logic [8:0]  c_sum;
	logic [23:0] rgb0_q, color_q;

	logic [RIW-1:0] scan_idx, slot_idx;
	logic [7:0]  s_lo, s_hi;
	logic        s_match;
	logic        idx_in_pal, req_in_pal, slot_ok;

	logic [8:0]  w0;
	logic [16:0] sum_r, sum_g, sum_b;

	assign cnt_sat = ({1'b0, cnt_q} > 5'(NUM_RANGES)) ? CW'(NUM_RANGES) : CW'(cnt_q);
	assign scan_idx = scan_q[RIW-1:0];
	assign slot_idx = RIW'(request.slot_number);
	assign slot_ok  = ({2'b00, request.slot_number} < 5'(NUM_RANGES));
	assign req_in_pal = ({1'b0, request.color_index} < 9'(PALETTE_SIZE));
	assign idx_in_pal = ({1'b0, idx_q} < 9'(PALETTE_SIZE));

	// range containment for the slot under scan
	assign s_lo = rng_first_q[scan_idx];
	assign s_hi = rng_last_q[scan_idx];
	assign s_match = (s_hi >= s_lo) && ({1'b0, s_hi} < 9'(PALETTE_SIZE))
		&& (idx_q >= s_lo) && (idx_q <= s_hi);

	assign sts.scan_done = (scan_q == cnt_sat);
	assign sts.hit       = hit_q;
	assign sts.div_last  = (div_cnt_q == DCW_W'(palcc_pkg::DIV_STEPS - 1));
	assign sts.blend_on  = blend_q;

	// shared 16x16 multiplier
	assign mul_a = ctl.mul_hi ? ft_q[31:16] : ft_q[15:0];
	assign prod  = mul_a * rate_q;
	assign s_sum = {phi_q[29:0], 2'b00} + {14'd0, plo_q[31:14]};

	// one restoring division step
	assign div_t    = {rem_q, dvd_q[15]};
	assign rem_next = (div_t >= {1'b0, n_q}) ? 9'(div_t - {1'b0, n_q}) : div_t[8:0];

	// rotated position within the range
	assign off_fwd = (rem_q == 9'd0) ? 8'd0 : 8'(n_q - rem_q);
	assign off_use = bwd_q ? rem_q[7:0] : off_fwd;
	assign pos     = idx_q - lo_q;
	assign c_sum   = {1'b0, pos} + {1'b0, off_use};
	assign c0      = (c_sum >= n_q) ? 8'(c_sum - n_q) : c_sum[7:0];
	assign c1      = (c0_q == 8'd0) ? 8'(n_q - 9'd1) : 8'(c0_q - 8'd1);

	always_comb begin
		unique case (ctl.rd_sel)
			palcc_pkg::RD_C0: rd_addr = AW'({1'b0, lo_q} + {1'b0, c0_q});
			palcc_pkg::RD_C1: rd_addr = AW'({1'b0, lo_q} + {1'b0, c1});
			default:          rd_addr = AW'(idx_q);
		endcase
	end

	// per-channel blend, top byte of each weighted sum
	assign w0    = 9'd256 - {1'b0, w1_q};
	assign sum_r = 17'(rgb0_q[23:16] * w0) + 17'(rd_q[23:16] * {1'b0, w1_q});
	assign sum_g = 17'(rgb0_q[15:8] * w0) + 17'(rd_q[15:8] * {1'b0, w1_q});
	assign sum_b = 17'(rgb0_q[7:0] * w0) + 17'(rd_q[7:0] * {1'b0, w1_q});

	always_ff @(posedge clk) begin
		if (ctl.wr_pal && req_in_pal) begin
			pal_mem[AW'(request.color_index)] <= request.color_value;
		end
		rd_q <= pal_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_RANGES; i++) begin
				rng_first_q[i] <= '0;
				rng_last_q[i]  <= '0;
				rng_speed_q[i] <= '0;
				rng_bwd_q[i]   <= 1'b0;
			end
			cnt_q  <= '0;
			scan_q <= '0;
			hit_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cnt_q <= cfg_wdata;
			end
			if (ctl.wr_rng && slot_ok) begin
				rng_first_q[slot_idx] <= request.first_entry;
				rng_last_q[slot_idx]  <= request.last_entry;
				rng_speed_q[slot_idx] <= request.cycle_rate;
				rng_bwd_q[slot_idx]   <= request.reverse_dir;
			end
			if (ctl.accept_query) begin
				scan_q <= '0;
				hit_q  <= 1'b0;
			end else if (ctl.scan_step) begin
				scan_q <= scan_q + CW'(1);
				if (s_match) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept_query) begin
			idx_q   <= request.color_index;
			ft_q    <= request.frame_time;
			blend_q <= request.blend_on;
		end
		if (ctl.scan_step && s_match) begin
			lo_q   <= s_lo;
			n_q    <= 9'({1'b0, s_hi} - {1'b0, s_lo} + 9'd1);
			rate_q <= rng_speed_q[scan_idx];
			bwd_q  <= rng_bwd_q[scan_idx];
		end
		if (ctl.mul_hi) begin
			phi_q <= prod;
		end
		if (ctl.mul_lo) begin
			plo_q <= prod;
		end
		if (ctl.sum) begin
			dvd_q     <= s_sum[31:16];
			w1_q      <= s_sum[15:8];
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (ctl.div_step) begin
			rem_q     <= rem_next;
			dvd_q     <= {dvd_q[14:0], 1'b0};
			div_cnt_q <= div_cnt_q + DCW_W'(1);
		end
		if (ctl.adj) begin
			c0_q <= c0;
		end
		if (ctl.cap_rgb0) begin
			rgb0_q  <= rd_q;
			color_q <= rd_q;
		end
		if (ctl.blend) begin
			color_q <= {sum_r[15:8], sum_g[15:8], sum_b[15:8]};
		end
		if (ctl.cap_plain) begin
			color_q <= idx_in_pal ? rd_q : 24'd0;
		end
	end

	assign result.queried_index = idx_q;
	assign result.shown_color   = color_q;

endmodule

@@ hdl/palette_color_cycling.sv @@
// ----------------------------------------------------------------------------
// palette_color_cycling
// palette with color range cycling: loads entries and ranges, answers queries
// ----------------------------------------------------------------------------
//
// channel   signals                       transaction
// request   start, busy, request          accepted when start high, busy low
// result    done, result                  one cycle per query, cannot stall
// config    cfg_we, cfg_wdata             written whenever cfg_we is high
//
// palette and range loads leave busy low
// a query first scans the ranges (count = active ranges); when no range holds
// the index it reads the palette entry directly, else it scales the frame
// time, runs the 16-step serial modulo, reads two entries, blends if enabled
// reset clears the range table and the range count; palette needs writes
// the result strobe done lasts one cycle, the receiver cannot hold it off
//
module palette_color_cycling #(
	parameter int PALETTE_SIZE = palcc_pkg::DEF_PALETTE_SIZE,
	parameter int NUM_RANGES   = palcc_pkg::DEF_NUM_RANGES
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  palcc_pkg::in_item_t  request,
	output logic                 done,
	output palcc_pkg::out_item_t result,
	input  logic                 cfg_we,
	input  logic [3:0]           cfg_wdata
);

	// command and status between sequencer and datapath
	palcc_pkg::ctl_t ctl;
	palcc_pkg::sts_t sts;

	// sequencer: decodes the accepted command and walks the query steps
	palcc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_cmd (request.cmd),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy),
		.done    (done)
	);

	// datapath: palette ram, range table, multiplier, divider, blender
	palcc_dp #(
		.PALETTE_SIZE (PALETTE_SIZE),
		.NUM_RANGES   (NUM_RANGES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.request   (request),
		.ctl       (ctl),
		.sts       (sts),
		.result    (result)
	);

endmodule

@@ hdl/palcc_checker.sv @@
// ----------------------------------------------------------------------------
// palcc_checker
// port-level checks of the handshake timing of palette_color_cycling
// ----------------------------------------------------------------------------
`include "palette_color_cycling_macros.svh"

module palcc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input palcc_pkg::in_item_t  request,
	input logic                 done
);

	logic acc_query, acc_other;

	assign acc_query = start && !busy && (request.cmd == palcc_pkg::CMD_QUERY);
	assign acc_other = start && !busy && (request.cmd != palcc_pkg::CMD_QUERY);

	// a query transaction holds off the next request
	`PCC_ASSERT_NEXT(a_query_busy, acc_query, busy)
	// a load leaves the block free in the next cycle
	`PCC_ASSERT_NEXT(a_load_free, acc_other, !busy)
	// a result only comes while a query is under way
	`PCC_ASSERT_SAME(a_done_busy, done, busy)
	// the block is free right after a result
	`PCC_ASSERT_NEXT(a_done_free, done, !busy && !done)

endmodule

bind palette_color_cycling palcc_checker u_palcc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.request   (request),
	.done      (done)
);
